### rtl/windowed_peak_rms_meter_defines.svh
// Assertion helpers for the level meter.
`ifndef WINDOWED_PEAK_RMS_METER_DEFINES_SVH
`define WINDOWED_PEAK_RMS_METER_DEFINES_SVH
`ifndef SYNTHESIS
// pre holds -> post holds in the same cycle
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// pre holds -> post holds in the next cycle
`define ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, pre, post)
`define ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

### rtl/wprm_pkg.sv
package wprm_pkg;

	// sample and stream geometry
	localparam int SAMPLE_BITS = 24;
	localparam int POS_BITS    = 40;
	localparam int LEN_BITS    = 17;
	localparam int SUM_BITS    = 63;
	localparam int SQ_BITS     = 2 * SAMPLE_BITS;
	localparam int ROOT_BITS   = SQ_BITS / 2;

	localparam logic [LEN_BITS-1:0] MAX_WINDOW   = 17'd65536;
	localparam logic [LEN_BITS-1:0] LEN_AT_RESET = 17'd48000;

	// window queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	// closed window handed to the back end
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] peak;
		logic [SUM_BITS-1:0]    sum;
		logic [LEN_BITS-1:0]    count;
		logic [POS_BITS-1:0]    pos;
	} wprm_win_t;

	typedef struct packed {
		logic      push;
		wprm_win_t win;
	} wprm_push_t;

endpackage

### rtl/wprm_front.sv
module wprm_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [63:0]                  s_axis_tdata,  // sample[23:0], sample_position[63:24]
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [16:0]                  cfg_data,
	input  logic [wprm_pkg::Q_CW-1:0]    q_count,
	output wprm_pkg::wprm_push_t         push
);
	import wprm_pkg::*;

	logic [LEN_BITS-1:0]    win_len_q;
	logic [LEN_BITS-1:0]    eff_len;
	logic [SAMPLE_BITS-1:0] smp;
	logic [SAMPLE_BITS-1:0] mag;
	logic                   acc;
	logic [Q_CW-1:0]        busy;

	logic                   v_s1, v_s2;
	logic [SAMPLE_BITS-1:0] mag_s1, mag_s2;
	logic [POS_BITS-1:0]    pos_s1, pos_s2;
	logic [SQ_BITS-1:0]     sq_s2;

	logic [SAMPLE_BITS-1:0] peak_q, peak_new;
	logic [SUM_BITS-1:0]    sum_q, sum_new;
	logic [LEN_BITS-1:0]    cnt_q, cnt_new;
	logic                   close;

	// window length register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= LEN_AT_RESET;
		end else if (cfg_valid) begin
			win_len_q <= cfg_data;
		end
	end

	always_comb begin
		eff_len = win_len_q;
		if (win_len_q == '0) begin
			eff_len = LEN_BITS'(1);
		end else if (win_len_q > MAX_WINDOW) begin
			eff_len = MAX_WINDOW;
		end
	end

	// credit check: every request in flight may close a window
	assign busy          = q_count + Q_CW'(v_s1) + Q_CW'(v_s2);
	assign s_axis_tready = busy < Q_CW'(Q_DEPTH);
	assign acc           = s_axis_tvalid && s_axis_tready;

	// magnitude; most negative value maps to 2^(SAMPLE_BITS-1)
	assign smp = s_axis_tdata[SAMPLE_BITS-1:0];
	assign mag = smp[SAMPLE_BITS-1] ? (~smp + SAMPLE_BITS'(1)) : smp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	// stage 1: magnitude, stage 2: square
	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		pos_s1 <= s_axis_tdata[SAMPLE_BITS +: POS_BITS];
		mag_s2 <= mag_s1;
		pos_s2 <= pos_s1;
		sq_s2  <= SQ_BITS'(mag_s1) * SQ_BITS'(mag_s1);
	end

	// accumulate and detect window end
	assign peak_new = (mag_s2 > peak_q) ? mag_s2 : peak_q;
	assign sum_new  = sum_q + SUM_BITS'(sq_s2);
	assign cnt_new  = cnt_q + LEN_BITS'(1);
	assign close    = v_s2 && ((cnt_new >= eff_len) || (cnt_new == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else if (v_s2) begin
			if (close) begin
				peak_q <= '0;
				sum_q  <= '0;
				cnt_q  <= '0;
			end else begin
				peak_q <= peak_new;
				sum_q  <= sum_new;
				cnt_q  <= cnt_new;
			end
		end
	end

	always_comb begin
		push.push      = close;
		push.win.peak  = peak_new;
		push.win.sum   = sum_new;
		push.win.count = (cnt_new == '0) ? LEN_BITS'(1) : cnt_new;
		push.win.pos   = pos_s2;
	end

endmodule

### rtl/wprm_queue.sv
module wprm_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wprm_pkg::wprm_push_t      push,
	input  logic                      pop,
	output logic                      q_valid,
	output wprm_pkg::wprm_win_t       q_data,
	output logic [wprm_pkg::Q_CW-1:0] count
);
	import wprm_pkg::*;

	wprm_win_t       slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0] cnt_q;
	logic            do_pop;

	assign do_pop  = pop && (cnt_q != '0);
	assign q_valid = cnt_q != '0;
	assign q_data  = slot_q[rd_ptr_q];
	assign count   = cnt_q;

	always_ff @(posedge clk) begin
		if (push.push) begin
			slot_q[wr_ptr_q] <= push.win;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			cnt_q <= cnt_q + Q_CW'(push.push) - Q_CW'(do_pop);
		end
	end

endmodule

### rtl/wprm_back.sv
module wprm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  wprm_pkg::wprm_win_t q_data,
	output logic                q_pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [87:0]         m_axis_tdata   // window_peak[23:0], window_rms[47:24], end_position[87:48]
);
	import wprm_pkg::*;

	localparam int DIV_STEPS  = SUM_BITS;
	localparam int SQRT_STEPS = ROOT_BITS;
	localparam int STEP_BITS  = 6;
	localparam int REM_BITS   = LEN_BITS + 1;
	localparam int SREM_BITS  = ROOT_BITS + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT, ST_DONE} state_t;

	state_t                 state_q;
	logic [STEP_BITS-1:0]   step_q;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic [POS_BITS-1:0]    pos_q;
	logic [LEN_BITS-1:0]    dvs_q;
	logic [SUM_BITS-1:0]    dvd_q;
	logic [LEN_BITS-1:0]    rem_q;
	logic [SQ_BITS-1:0]     rad_q;
	logic [ROOT_BITS-1:0]   root_q;
	logic [SREM_BITS-1:0]   srem_q;
	logic                   out_valid_q;
	logic [87:0]            out_data_q;
	logic                   load_out;

	// restoring divide step
	logic [REM_BITS-1:0]    d_try;
	logic                   d_ge;
	logic [LEN_BITS-1:0]    d_rem;
	logic [SUM_BITS-1:0]    d_quo;

	// digit-by-digit square root step
	logic [SREM_BITS+1:0]   s_try;
	logic [SREM_BITS+1:0]   s_trial;
	logic                   s_ge;
	logic [SREM_BITS-1:0]   s_rem;
	logic [ROOT_BITS-1:0]   s_root;

	always_comb begin
		d_try = {rem_q, dvd_q[SUM_BITS-1]};
		d_ge  = d_try >= {1'b0, dvs_q};
		d_rem = d_ge ? LEN_BITS'(d_try - {1'b0, dvs_q}) : d_try[LEN_BITS-1:0];
		d_quo = {dvd_q[SUM_BITS-2:0], d_ge};
	end

	always_comb begin
		s_try   = {srem_q, rad_q[SQ_BITS-1 -: 2]};
		s_trial = {1'b0, root_q, 2'b01};
		s_ge    = s_try >= s_trial;
		s_rem   = s_ge ? SREM_BITS'(s_try - s_trial) : s_try[SREM_BITS-1:0];
		s_root  = {root_q[ROOT_BITS-2:0], s_ge};
	end

	assign q_pop         = (state_q == ST_IDLE) && q_valid;
	assign load_out      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// sequencer: divide, then root, then output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			peak_q      <= '0;
			pos_q       <= '0;
			dvs_q       <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			rad_q       <= '0;
			root_q      <= '0;
			srem_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						peak_q  <= q_data.peak;
						pos_q   <= q_data.pos;
						dvs_q   <= q_data.count;
						dvd_q   <= q_data.sum;
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= d_rem;
					dvd_q  <= d_quo;
					step_q <= step_q + STEP_BITS'(1);
					if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
						// mean never exceeds the largest square
						rad_q   <= d_quo[SQ_BITS-1:0];
						root_q  <= '0;
						srem_q  <= '0;
						step_q  <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					srem_q <= s_rem;
					root_q <= s_root;
					rad_q  <= {rad_q[SQ_BITS-3:0], 2'b00};
					step_q <= step_q + STEP_BITS'(1);
					if (step_q == STEP_BITS'(SQRT_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						out_data_q <= {pos_q, root_q, peak_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/windowed_peak_rms_meter.sv
// Throughput: one sample per cycle while the window queue has room.
// Result path from the closing sample's request to result valid: 2 front stages, queue,
//   63 divide steps, 24 square-root steps, output register.
// The back end handles one window at a time and takes no new one until its result is
//   loaded into the output register; short windows fill the 4-entry queue and stall the sample input.
// Reset (arst_n low, asynchronous): accumulators, queue and output cleared, window length 48000.
`include "windowed_peak_rms_meter_defines.svh"
module windowed_peak_rms_meter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // sample[23:0], sample_position[63:24]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,   // window_peak[23:0], window_rms[47:24], end_position[87:48]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data        // window_length
);
	import wprm_pkg::*;

	wprm_push_t      push;
	logic            q_valid;
	logic            q_pop;
	wprm_win_t       q_data;
	logic [Q_CW-1:0] q_count;

	wprm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.q_count       (q_count),
		.push          (push)
	);

	wprm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (q_pop),
		.q_valid (q_valid),
		.q_data  (q_data),
		.count   (q_count)
	);

	wprm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// credit scheme keeps the queue from overflowing
	`ASSERT_IMP(a_queue_room, clk, arst_n, push.push, q_count < Q_CW'(Q_DEPTH))
	// back end takes one window and is then busy
	`ASSERT_NXT(a_single_pop, clk, arst_n, q_pop, !q_pop)
	// root of mean square never exceeds the peak
	`ASSERT_IMP(a_rms_le_peak, clk, arst_n, m_axis_tvalid, m_axis_tdata[47:24] <= m_axis_tdata[23:0])

endmodule

### bench/level_report_checker.sv
module level_report_checker
	import wprm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // sample[23:0], sample_position[63:24]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [87:0] m_axis_tdata,   // window_peak[23:0], window_rms[47:24], end_position[87:48]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [16:0] cfg_data,       // window_length
	output int          mismatch_count,
	output int          reports_due
);

	// one closed window, laid out like m_axis_tdata (peak in the low bits)
	typedef struct packed {
		logic [POS_BITS-1:0]    pos;
		logic [SAMPLE_BITS-1:0] rms;
		logic [SAMPLE_BITS-1:0] peak;
	} level_report_t;

	level_report_t          pending_reports[$];
	logic [LEN_BITS-1:0]    window_len;
	logic [SAMPLE_BITS-1:0] peak_now;
	logic [SUM_BITS-1:0]    energy_sum;
	logic [LEN_BITS-1:0]    samples_in_window;
	int                     errors_seen;

	// floor square root, one result bit per trial from the top down
	function automatic logic [SAMPLE_BITS-1:0] root_floor(input logic [SUM_BITS-1:0] x);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (64'(trial) * 64'(trial) <= 64'(x))
				root = trial;
		end
		return root[SAMPLE_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		level_report_t          got;
		level_report_t          want;
		logic [SAMPLE_BITS-1:0] raw;
		logic [SAMPLE_BITS-1:0] mag;
		logic [LEN_BITS-1:0]    limit_len;
		logic [SUM_BITS-1:0]    mean;
		if (!arst_n) begin
			pending_reports.delete();
			window_len        = LEN_AT_RESET;
			peak_now          = '0;
			energy_sum        = '0;
			samples_in_window = '0;
			errors_seen       = 0;
		end else begin
			// compare each delivered report with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pending_reports.size() == 0) begin
					$display("%0t: unexpected report, expected none, got peak %0d rms %0d end %0d",
						$time, got.peak, got.rms, got.pos);
					errors_seen++;
				end else begin
					want = pending_reports.pop_front();
					if (got.peak !== want.peak) begin
						$display("%0t: window_peak expected %0d got %0d", $time, want.peak, got.peak);
						errors_seen++;
					end
					if (got.rms !== want.rms) begin
						$display("%0t: window_rms expected %0d got %0d", $time, want.rms, got.rms);
						errors_seen++;
					end
					if (got.pos !== want.pos) begin
						$display("%0t: end_position expected %0d got %0d", $time, want.pos, got.pos);
						errors_seen++;
					end
				end
			end

			// accumulate the sample; a full window yields one report
			if (s_axis_tvalid && s_axis_tready) begin
				raw = s_axis_tdata[SAMPLE_BITS-1:0];
				mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
				if (mag > peak_now)
					peak_now = mag;
				energy_sum        = energy_sum + SUM_BITS'(mag) * SUM_BITS'(mag);
				samples_in_window = samples_in_window + 1'b1;
				// zero means one, anything past the largest window saturates
				limit_len = (window_len == '0) ? LEN_BITS'(1) :
					(window_len > MAX_WINDOW) ? MAX_WINDOW : window_len;
				if (samples_in_window >= limit_len || samples_in_window == '0) begin
					mean = energy_sum / ((samples_in_window == '0) ? SUM_BITS'(1) :
						SUM_BITS'(samples_in_window));
					want.peak = peak_now;
					want.rms  = root_floor(mean);
					want.pos  = s_axis_tdata[SAMPLE_BITS+POS_BITS-1:SAMPLE_BITS];
					pending_reports.push_back(want);
					peak_now          = '0;
					energy_sum        = '0;
					samples_in_window = '0;
				end
			end

			// length change keeps the running window
			if (cfg_valid && cfg_ready)
				window_len = cfg_data;
		end
		mismatch_count <= errors_seen;
		reports_due    <= pending_reports.size();
	end

endmodule

### bench/windowed_peak_rms_meter_tb.sv
module windowed_peak_rms_meter_tb;
	import wprm_pkg::*;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;   // sample[23:0], sample_position[63:24]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;         // window_peak[23:0], window_rms[47:24], end_position[87:48]
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data      = '0;   // window_length
	int          mismatch_count;
	int          reports_due;

	int                  src_idle_pct  = 0;
	int                  sink_idle_pct = 0;
	logic [POS_BITS-1:0] stream_pos    = '0;

	windowed_peak_rms_meter DUT (.*);
	level_report_checker level_check (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run guard
	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end

	// random back-pressure on the report side
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// one sample request; valid stays high into the next call unless a gap is drawn
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {stream_pos, smp};
		stream_pos = stream_pos + 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// full scale, near zero, anything, or low level audio; positions jump now and then
	task automatic send_random_sample();
		logic [SAMPLE_BITS-1:0] smp;
		case ($urandom_range(9))
			0:             smp = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			1:             smp = 24'($urandom_range(2)) - 24'd1;
			2, 3, 4, 5:    smp = 24'($urandom);
			default:       smp = 24'($signed(12'($urandom)));
		endcase
		if ($urandom_range(49) == 0)
			stream_pos = POS_BITS'({$urandom, $urandom});
		send_sample(smp);
	endtask

	// hold the input until every predicted report is out, then let the back end settle
	task automatic drain_meter();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (reports_due != 0);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_window_length(input logic [LEN_BITS-1:0] len);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [LEN_BITS-1:0] len;
		int                  span;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset length: extremes accumulate without closing a window
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h000000);
		send_sample(24'hFFFFFF);
		send_sample(24'h000001);
		// shortened below the count: the next sample closes with the true count
		drain_meter();
		write_window_length(17'd3);
		send_sample(24'd100);
		// zero length acts as one; position wraps from all ones
		drain_meter();
		write_window_length('0);
		stream_pos = '1;
		send_sample(24'h800000);
		send_sample(24'h7FFFFF);
		drain_meter();
		write_window_length(17'd1);
		send_sample(24'hFFFFFF);
		send_sample(24'h000001);
		// above the largest window, then the largest, then cut short
		drain_meter();
		write_window_length('1);
		repeat (3) send_sample(24'h800000);
		drain_meter();
		write_window_length(MAX_WINDOW);
		repeat (2) send_sample(24'h7FFFFF);
		drain_meter();
		write_window_length(17'd2);
		send_sample(24'h123456);
		drain_meter();
		write_window_length(17'd4);
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h000000);
		send_sample(24'hABCDEF);

		// random phases under three idling patterns
		for (int mode = 0; mode < 3; mode++) begin
			src_idle_pct  = (mode == 0) ? 35 : (mode == 1) ? 73 : 0;
			sink_idle_pct = (mode == 0) ? 73 : (mode == 1) ? 35 : 0;
			for (int sent = 0; sent < 480; ) begin
				drain_meter();
				case ($urandom_range(19))
					0:       len = '0;
					1:       len = 17'd1;
					2:       len = LEN_BITS'($urandom_range(100, 300));
					3:       len = $urandom_range(1) ? MAX_WINDOW : '1;
					default: len = LEN_BITS'($urandom_range(2, 40));
				endcase
				write_window_length(len);
				if (len <= 17'd1)
					span = $urandom_range(1, 12);
				else if (len >= MAX_WINDOW)
					span = $urandom_range(3, 30);
				else if (len >= 17'd100)
					span = $urandom_range(len, len + len / 2);
				else
					span = $urandom_range(1, 4 * len);
				for (int k = 0; k < span; k++) begin
					send_random_sample();
					sent++;
				end
				// long windows never fill here, so cut them short; others sometimes
				if (len >= MAX_WINDOW || $urandom_range(3) == 0) begin
					drain_meter();
					write_window_length(LEN_BITS'($urandom_range(1, 8)));
					span = $urandom_range(1, 10);
					for (int k = 0; k < span; k++) begin
						send_random_sample();
						sent++;
					end
				end
			end
		end

		drain_meter();
		@(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/wprm_pkg.sv
rtl/wprm_front.sv
rtl/wprm_queue.sv
rtl/wprm_back.sv
rtl/windowed_peak_rms_meter.sv
bench/level_report_checker.sv
bench/windowed_peak_rms_meter_tb.sv
